// ===== src/ldos_pkg.sv =====
// ldos_pkg: shared types, constants and helpers for the density of states block.
// No dependencies.
`timescale 1ns / 1ps
package ldos_pkg;
	localparam int unsigned MaxLevelsDef = 256;
	localparam int unsigned MaxPointsDef = 64;
	localparam int unsigned CellsDef     = 4;
	localparam int unsigned CfgIdxW      = 3;
	localparam int unsigned CfgDataW     = 32;
	localparam int unsigned DivSteps     = 49;

	typedef enum logic [CfgIdxW-1:0] {
		REG_E_MIN     = 3'd0,
		REG_DELTA_E   = 3'd1,
		REG_NUM_PTS   = 3'd2,
		REG_HALF_W_SQ = 3'd3,
		REG_SCALE     = 3'd4
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_POINT,
		ST_READ,
		ST_DIV,
		ST_MUL,
		ST_OUT
	} ldos_state_t;

	// per-cell control from the sequencer
	typedef struct packed {
		logic start;
		logic step;
	} div_ctl_t;

	function automatic logic [31:0] sat_s32(input logic signed [40:0] v);
		logic [31:0] r;
		if (v > 41'sd2147483647) r = 32'h7FFF_FFFF;
		else if (v < -41'sd2147483648) r = 32'h8000_0000;
		else r = v[31:0];
		return r;
	endfunction
endpackage

// ===== src/ldos_if.sv =====
// ldos_if: valid/ready channel interface with a parameterized payload type.
// Depends on nothing.
`timescale 1ns / 1ps
interface ldos_if #(parameter type payload_t = logic) (input logic clk);
	logic     valid;
	logic     ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== src/ldos_ram.sv =====
// ldos_ram: generic single-port write, single-port registered read RAM.
// Depends on nothing.
`timescale 1ns / 1ps
module ldos_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// ===== src/ldos_cell.sv =====
// ldos_cell: one chain cell. Takes a level, forms the Lorentzian denominator and
// runs a restoring divide of 2^32 by it one bit a cycle. Depends on ldos_pkg.
`timescale 1ns / 1ps
module ldos_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  ldos_pkg::div_ctl_t  ctl,
	input  logic                load_in,
	input  logic [31:0]         level_in,
	input  logic [31:0]         point_e,
	input  logic [31:0]         half_w_sq,
	output logic                load_out,
	output logic [31:0]         level_out,
	output logic [32:0]         quot
);
	import ldos_pkg::*;

	logic        have_q;
	logic [31:0] level_q;
	logic [48:0] den_q;
	logic [49:0] rem_q;
	logic [32:0] quot_q;
	logic signed [32:0] diff;
	logic [31:0] mag;
	logic [63:0] sq;
	logic [48:0] den;
	logic [49:0] trial;
	logic [5:0]  bit_q;

	// shift chain of level registers: each cell hands its level to the next
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q <= 1'b0;
		end else if (ctl.start) begin
			have_q <= load_in;
		end
	end
	always_ff @(posedge clk) begin
		if (ctl.start) level_q <= level_in;
	end
	assign load_out  = have_q;
	assign level_out = level_q;

	always_comb begin
		diff  = $signed({point_e[31], point_e}) - $signed({level_in[31], level_in});
		mag   = diff[32] ? 32'(-diff) : diff[31:0];
		sq    = 64'(mag) * 64'(mag);
		den   = 49'(sq[63:16]) + 49'(half_w_sq);
		if (den == '0) den = 49'd1;
		trial = {rem_q[48:0], (bit_q == 6'd16)} - {1'b0, den_q};
	end

	// dividend 2^32: single one bit fed in at position 32 (bit index 16 of 49)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_q <= '0;
		end else if (ctl.start) begin
			bit_q <= '0;
		end else if (ctl.step) begin
			bit_q <= bit_q + 6'd1;
		end
	end
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			den_q  <= den;
			rem_q  <= '0;
			quot_q <= '0;
		end else if (ctl.step) begin
			if (!trial[49]) begin
				rem_q  <= trial;
				quot_q <= {quot_q[31:0], 1'b1};
			end else begin
				rem_q  <= {rem_q[48:0], (bit_q == 6'd16)};
				quot_q <= {quot_q[31:0], 1'b0};
			end
		end
	end
	assign quot = load_in ? quot_q : '0;
endmodule

// ===== src/lorentzian_density_of_states.sv =====
// lorentzian_density_of_states: top level with level store, sequencer and cell row.
// Depends on ldos_pkg, ldos_if, ldos_ram, ldos_cell.
//
// channel  | dir  | payload
// in_ch    | sink | level_energy[31:0] signed, last_level
// out_ch   | src  | point_energy[31:0] signed, density[31:0], last_point
// cfg_*    | in   | cfg_we, cfg_idx[2:0], cfg_data[31:0]
//
// Schedule: levels are stored while in LOAD. After the last level, each grid point
// is worked in groups of CELLS levels: per group one issue state, up to CELLS reads,
// a 49-step restoring divide and one settle step, the cells working side by side;
// then multiply and output.
// Reset: clears level count, registers to defaults, sequencer to LOAD.
// Stalls: out_ch backpressure holds the current point; no input taken during the walk.
`timescale 1ns / 1ps
module lorentzian_density_of_states #(
	parameter int unsigned MAX_LEVELS = ldos_pkg::MaxLevelsDef,
	parameter int unsigned MAX_POINTS = ldos_pkg::MaxPointsDef,
	parameter int unsigned CELLS      = ldos_pkg::CellsDef
) (
	input  logic                          clk,
	input  logic                          arst_n,
	ldos_if.sink                          in_ch,
	ldos_if.source                        out_ch,
	input  logic                          cfg_we,
	input  logic [ldos_pkg::CfgIdxW-1:0]  cfg_idx,
	input  logic [ldos_pkg::CfgDataW-1:0] cfg_data
);
	import ldos_pkg::*;

	localparam int unsigned AW = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
	localparam int unsigned CW = $clog2(MAX_LEVELS + 1);
	localparam int unsigned PW = $clog2(MAX_POINTS + 1);
	localparam int unsigned GW = $clog2(CELLS + 1);

	// configuration registers
	logic [31:0] e_min_q, half_w_q, scale_q;
	logic [30:0] delta_q;
	logic [6:0]  npts_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			e_min_q  <= '0;
			delta_q  <= 31'd65536;
			npts_q   <= 7'd64;
			half_w_q <= 32'd16384;
			scale_q  <= 32'd10430;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_E_MIN:     e_min_q  <= cfg_data;
				REG_DELTA_E:   delta_q  <= cfg_data[30:0];
				REG_NUM_PTS:   npts_q   <= cfg_data[6:0];
				REG_HALF_W_SQ: half_w_q <= cfg_data;
				REG_SCALE:     scale_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	ldos_state_t state_q, state_d;
	logic [CW-1:0] count_q;
	logic [CW-1:0] rd_q;       // next store address to read
	logic [GW-1:0] fill_q;     // levels shifted into the row this group
	logic [5:0]    step_q;
	logic [PW-1:0] pt_q, npts_lim;
	logic [31:0]   pe_q;
	logic signed [40:0] pe_next;
	logic [31:0]   sum_q;
	logic [63:0]   prod_s1;
	logic [31:0]   dens_q;
	logic          last_q;
	logic          rd_pend_q;

	logic          in_fire, out_fire, wr_en;
	logic [31:0]   rdata;
	div_ctl_t      ctl;

	assign in_fire  = in_ch.valid && in_ch.ready;
	assign out_fire = out_ch.valid && out_ch.ready;
	assign wr_en    = in_fire && (count_q < CW'(MAX_LEVELS));
	assign npts_lim = (npts_q > 7'(MAX_POINTS)) ? PW'(MAX_POINTS) : PW'(npts_q);
	assign pe_next  = $signed({{9{pe_q[31]}}, pe_q}) + $signed({10'd0, delta_q});

	ldos_ram #(.WIDTH(32), .DEPTH(MAX_LEVELS)) u_store (
		.clk  (clk),
		.we   (wr_en),
		.waddr(count_q[AW-1:0]),
		.wdata(in_ch.data.level_energy),
		.raddr(rd_q[AW-1:0]),
		.rdata(rdata)
	);

	// row of cells; level data shifts from cell 0 outward during ST_READ
	logic [31:0] lvl [CELLS+1];
	logic        ld  [CELLS+1];
	logic [32:0] q   [CELLS];
	logic        shift;
	assign shift  = (state_q == ST_READ) && rd_pend_q;
	assign lvl[0] = rdata;
	assign ld[0]  = 1'b1;
	assign ctl.start = shift;
	// last divide cycle is a settle cycle: quotients final, sum taken
	assign ctl.step  = (state_q == ST_DIV) && (step_q != 6'(DivSteps));

	for (genvar c = 0; c < CELLS; c++) begin : g_cell
		ldos_cell u_cell (
			.clk(clk), .arst_n(arst_n), .ctl(ctl),
			.load_in(ld[c]), .level_in(lvl[c]),
			.point_e(pe_q), .half_w_sq(half_w_q),
			.load_out(ld[c+1]), .level_out(lvl[c+1]),
			.quot(q[c])
		);
	end

	// reduction over the row after each divide group; the newest levels sit in
	// the lowest cells, so only cells below the fill count take part
	logic [35:0] grp_sum;
	always_comb begin
		grp_sum = 36'(sum_q);
		for (int c = 0; c < CELLS; c++) begin
			if (GW'(c) < fill_q) grp_sum = grp_sum + 36'(q[c]);
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_LOAD:  if (in_fire && in_ch.data.last_level)
				state_d = (npts_lim == '0) ? ST_LOAD : ST_POINT;
			ST_POINT: state_d = (rd_q >= count_q) ? ST_MUL : ST_READ;
			ST_READ:  if (shift && (fill_q + GW'(1) == GW'(CELLS) || rd_q >= count_q))
				state_d = ST_DIV;
			ST_DIV:   if (step_q == 6'(DivSteps)) state_d = ST_POINT;
			ST_MUL:   state_d = ST_OUT;
			ST_OUT:   if (out_fire) state_d = (pt_q + PW'(1) == npts_lim) ? ST_LOAD : ST_POINT;
			default:  state_d = ST_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_LOAD;
			count_q   <= '0;
			rd_q      <= '0;
			fill_q    <= '0;
			step_q    <= '0;
			pt_q      <= '0;
			rd_pend_q <= 1'b0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_LOAD: begin
					if (in_fire && in_ch.data.last_level) begin
						pt_q <= '0;
						rd_q <= '0;
					end
					if (in_fire && in_ch.data.last_level && npts_lim == '0) count_q <= '0;
					else if (wr_en) count_q <= count_q + CW'(1);
				end
				ST_POINT: begin
					fill_q    <= '0;
					rd_pend_q <= 1'b0;
					if (rd_q < count_q) begin
						rd_q      <= rd_q + CW'(1);
						rd_pend_q <= 1'b1;
					end
				end
				ST_READ: begin
					if (shift) fill_q <= fill_q + GW'(1);
					if (state_d == ST_READ && rd_q < count_q) begin
						rd_q      <= rd_q + CW'(1);
						rd_pend_q <= 1'b1;
					end else begin
						rd_pend_q <= 1'b0;
					end
					step_q <= '0;
				end
				ST_DIV: step_q <= step_q + 6'd1;
				ST_OUT: if (out_fire) begin
					pt_q <= pt_q + PW'(1);
					rd_q <= '0;
					if (pt_q + PW'(1) == npts_lim) count_q <= '0;
				end
				default: ;
			endcase
		end
	end

	// point energy, running sum and scaled density
	always_ff @(posedge clk) begin
		if (state_q == ST_LOAD) begin
			pe_q  <= e_min_q;
			sum_q <= '0;
		end else if (state_q == ST_DIV && state_d == ST_POINT) begin
			sum_q <= (grp_sum > 36'hFFFF_FFFF) ? 32'hFFFF_FFFF : grp_sum[31:0];
		end else if (state_q == ST_OUT && out_fire) begin
			pe_q  <= sat_s32(pe_next);
			sum_q <= '0;
		end
		if (state_q == ST_MUL) prod_s1 <= 64'(sum_q) * 64'(scale_q);
		if (state_q == ST_POINT && rd_q >= count_q) last_q <= (pt_q + PW'(1) == npts_lim);
	end
	assign dens_q = (prod_s1[63:48] != '0) ? 32'hFFFF_FFFF : prod_s1[47:16];

	assign in_ch.ready              = (state_q == ST_LOAD);
	assign out_ch.valid             = (state_q == ST_OUT);
	assign out_ch.data.point_energy = pe_q;
	assign out_ch.data.density      = dens_q;
	assign out_ch.data.last_point   = last_q;

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ch.ready && out_ch.valid)) else $error("in and out both open");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_LEVELS)) else $error("level count overflow");
	a_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		out_fire && out_ch.data.last_point |=> count_q == '0) else $error("count not cleared");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |=> $stable(out_ch.data.density)) else $error("density moved");
endmodule

// ===== tb/ldos_tb_pkg.sv =====
// ldos_tb_pkg: payload types for the level and point channels of the testbench.
// Depends on nothing; used by ldos_checker and lorentzian_density_of_states_tb.
`timescale 1ns / 1ps
package ldos_tb_pkg;
	typedef struct packed {
		logic [31:0] level_energy;
		logic        last_level;
	} level_t;

	typedef struct packed {
		logic [31:0] point_energy;
		logic [31:0] density;
		logic        last_point;
	} point_t;
endpackage

// ===== tb/ldos_checker.sv =====
// ldos_checker: watches the level, point and register ports, predicts every grid point
// and compares it with the block's output. Depends on ldos_pkg, ldos_tb_pkg, ldos_if.
`timescale 1ns / 1ps
module ldos_checker #(
	parameter int unsigned MAX_LEVELS = 256,
	parameter int unsigned MAX_POINTS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	ldos_if             in_ch,
	ldos_if             out_ch,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_idx,
	input  logic [31:0] cfg_data,
	output int          errors,
	output int          pending
);
	import ldos_pkg::*;
	import ldos_tb_pkg::*;

	logic signed [31:0] grid_start;
	logic [30:0]        grid_step;
	logic [6:0]         grid_points;
	logic [31:0]        gamma_sq;
	logic [31:0]        dos_scale;

	logic [31:0] level_mem [MAX_LEVELS];
	int unsigned level_cnt;
	point_t      spectrum_q[$];

	// saturated sum of Lorentzian terms at one grid energy
	function automatic logic [63:0] lorentz_sum(input logic signed [63:0] e);
		logic [63:0]        sum;
		logic [63:0]        d;
		logic [63:0]        den;
		logic signed [63:0] diff;
		sum = 0;
		for (int k = 0; k < level_cnt; k++) begin
			diff = e - {{32{level_mem[k][31]}}, level_mem[k]};
			d    = diff < 0 ? -diff : diff;
			den  = ((d * d) >> 16) + {32'd0, gamma_sq};
			if (den == 0)
				den = 1;
			sum = sum + (64'h1_0000_0000 / den);
			if (sum > 64'hFFFF_FFFF)
				sum = 64'hFFFF_FFFF;
		end
		return sum;
	endfunction

	task automatic predict_spectrum();
		int unsigned        npts;
		logic signed [63:0] e;
		logic [63:0]        dens;
		point_t             p;
		npts = grid_points > MAX_POINTS ? MAX_POINTS : grid_points;
		for (int unsigned i = 0; i < npts; i++) begin
			e = 64'(grid_start) + 64'(i) * $signed({33'd0, grid_step});
			if (e > 64'sd2147483647)
				e = 64'sd2147483647;
			if (e < -64'sd2147483648)
				e = -64'sd2147483648;
			dens = (lorentz_sum(e) * {32'd0, dos_scale}) >> 16;
			if (dens > 64'hFFFF_FFFF)
				dens = 64'hFFFF_FFFF;
			p.point_energy = e[31:0];
			p.density      = dens[31:0];
			p.last_point   = (i + 1 == npts);
			spectrum_q.push_back(p);
		end
		level_cnt = 0;
	endtask

	always @(posedge clk or negedge arst_n) begin
		level_t lv;
		point_t got;
		point_t want;
		if (!arst_n) begin
			grid_start  <= 0;
			grid_step   <= 31'd65536;
			grid_points <= 7'd64;
			gamma_sq    <= 32'd16384;
			dos_scale   <= 32'd10430;
			level_cnt   = 0;
			spectrum_q.delete();
			errors      <= 0;
			pending     <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_idx))
					REG_E_MIN:     grid_start  <= cfg_data;
					REG_DELTA_E:   grid_step   <= cfg_data[30:0];
					REG_NUM_PTS:   grid_points <= cfg_data[6:0];
					REG_HALF_W_SQ: gamma_sq    <= cfg_data;
					REG_SCALE:     dos_scale   <= cfg_data;
					default: ;
				endcase
			end
			if (out_ch.valid && out_ch.ready) begin
				got = out_ch.data;
				if (spectrum_q.size() == 0) begin
					$display("%0t: unexpected point energy=%h density=%h last=%b", $time,
						got.point_energy, got.density, got.last_point);
					errors <= errors + 1;
				end else begin
					want = spectrum_q.pop_front();
					if (got !== want) begin
						$display("%0t: point mismatch expected e=%h d=%h l=%b got e=%h d=%h l=%b",
							$time, want.point_energy, want.density, want.last_point,
							got.point_energy, got.density, got.last_point);
						errors <= errors + 1;
					end
				end
			end
			if (in_ch.valid && in_ch.ready) begin
				lv = in_ch.data;
				if (level_cnt < MAX_LEVELS) begin
					level_mem[level_cnt] = lv.level_energy;
					level_cnt++;
				end
				if (lv.last_level)
					predict_spectrum();
			end
			pending <= spectrum_q.size();
		end
	end
endmodule

// ===== tb/lorentzian_density_of_states_tb.sv =====
// lorentzian_density_of_states_tb: stimulus, register setup and verdict for the block.
// Depends on ldos_pkg, ldos_tb_pkg, ldos_if, ldos_checker and the block itself.
`timescale 1ns / 1ps
module lorentzian_density_of_states_tb;
	import ldos_pkg::*;
	import ldos_tb_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_idx;
	logic [31:0] cfg_data;
	int          errors;
	int          pending;

	// sender idle / receiver stall percentages for the current phase
	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;
	bit          hold_req;
	int unsigned levels_sent;
	int unsigned spectra_sent;

	// mirror of the grid setup, used to aim levels near grid points
	logic signed [31:0] cur_start;
	logic [30:0]        cur_step;

	ldos_if #(.payload_t(level_t)) in_ch (clk);
	ldos_if #(.payload_t(point_t)) out_ch (clk);

	lorentzian_density_of_states DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_ch),
		.out_ch   (out_ch),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data)
	);

	ldos_checker checker_i (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_ch),
		.out_ch   (out_ch),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.errors   (errors),
		.pending  (pending)
	);

	initial clk = 0;
	always #2 clk = ~clk;

	// run limit: far above the slowest legal run
	initial begin
		#20ms;
		$display("DONE: errors detected");
		$finish;
	end

	// receiver: random stalls, plus one long hold-off counted here when asked
	initial begin
		int unsigned hold_left;
		hold_left    = 0;
		out_ch.ready = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req && hold_left == 0) begin
				hold_req  = 0;
				hold_left = 2000;
			end
			if (hold_left > 0) begin
				out_ch.ready <= 0;
				hold_left--;
			end else begin
				out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// one level transaction; valid stays high into the next call unless a gap is taken
	task automatic send_level(input logic [31:0] energy, input logic last);
		level_t lv;
		lv.level_energy = energy;
		lv.last_level   = last;
		in_ch.valid <= 1;
		in_ch.data  <= lv;
		do @(posedge clk); while (!in_ch.ready);
		levels_sent++;
		if (last)
			spectra_sent++;
		if ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	// let all points drain, then allow for a walk that emits nothing
	task automatic wait_idle();
		in_ch.valid <= 0;
		@(posedge clk);
		wait (pending == 0);
		repeat (300) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [31:0] value);
		cfg_we   <= 1;
		cfg_idx  <= idx;
		cfg_data <= value;
		@(posedge clk);
		if (idx == REG_E_MIN)
			cur_start = value;
		if (idx == REG_DELTA_E)
			cur_step = value[30:0];
	endtask

	task automatic setup_grid(input logic [31:0] start, input logic [31:0] step,
			input logic [31:0] npts, input logic [31:0] hw, input logic [31:0] scl);
		write_reg(REG_E_MIN, start);
		write_reg(REG_DELTA_E, step);
		write_reg(REG_NUM_PTS, npts);
		write_reg(REG_HALF_W_SQ, hw);
		write_reg(REG_SCALE, scl);
		cfg_we <= 0;
		@(posedge clk);
	endtask

	// random level: mostly close to a grid point so terms are large, else anywhere
	function automatic logic [31:0] pick_level();
		logic [31:0] v;
		if ($urandom_range(2) == 0)
			v = $urandom;
		else
			v = cur_start + $urandom_range(0, 7) * cur_step + $urandom_range(0, 4096) - 2048;
		return v;
	endfunction

	function automatic logic [31:0] pick_field(input logic [31:0] lo_val,
			input logic [31:0] hi_val, input logic [31:0] typical);
		logic [31:0] v;
		case ($urandom_range(5))
			0: v = lo_val;
			1: v = hi_val;
			2: v = $urandom;
			default: v = typical;
		endcase
		return v;
	endfunction

	initial begin
		int unsigned nlev;
		int unsigned mode;
		in_ch.valid    = 0;
		in_ch.data     = '0;
		cfg_we         = 0;
		cfg_idx        = REG_E_MIN;
		cfg_data       = 0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_req       = 0;
		levels_sent    = 0;
		spectra_sent   = 0;
		cur_start      = 0;
		cur_step       = 31'd65536;
		arst_n         = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: reset grid, field extremes
		send_level(32'h0000_0000, 0);
		send_level(32'h7FFF_FFFF, 0);
		send_level(32'h8000_0000, 1);
		send_level(32'h0001_0000, 1);
		wait_idle();

		// top of the range: energy overflow saturates, zero width hits zero denominator
		setup_grid(32'h7FFF_0000, 32'h7FFF_FFFF, 3, 0, 32'hFFFF_FFFF);
		send_level(32'h7FFF_0000, 0);
		send_level(32'h7FFF_FFFF, 1);
		wait_idle();

		// no points at all; the count must still clear
		setup_grid(32'h8000_0000, 0, 0, 1, 0);
		send_level(32'h1234_5678, 1);
		wait_idle();

		// point count above the limit, zero step, zero scale
		setup_grid(32'h8000_0000, 0, 127, 1, 0);
		send_level(32'h8000_0000, 1);
		wait_idle();

		// store full: two levels past capacity are dropped, the last still starts a walk
		setup_grid(32'hFFFF_0000, 32'h0000_8000, 2, 32'h0001_0000, 32'h0001_0000);
		for (int i = 0; i < 258; i++)
			send_level(pick_level(), i == 257);
		wait_idle();

		// random phases cycling through the idling patterns
		for (int p = 0; p < 12; p++) begin
			setup_grid(pick_field(32'h8000_0000, 32'h7FFF_FFFF,
					($urandom_range(0, 20) << 16) - (10 << 16)),
				pick_field(0, 32'h7FFF_FFFF, $urandom_range(1, 1 << 17)),
				($urandom_range(7) == 0) ? pick_field(0, 127, 64) : $urandom_range(1, 6),
				pick_field(0, 32'hFFFF_FFFF, $urandom_range(1, 1 << 18)),
				pick_field(0, 32'hFFFF_FFFF, $urandom_range(1, 1 << 17)));
			mode = p % 4;
			send_idle_pct  = (mode == 1) ? 58 : (mode == 3) ? 12 : 0;
			recv_stall_pct = (mode == 2) ? 58 : (mode == 3) ? 12 : 0;
			if (p == 5)
				hold_req = 1;
			for (int s = 0; s < 2; s++) begin
				nlev = $urandom_range(1, 3);
				for (int k = 0; k < nlev; k++)
					send_level(pick_level(), k == nlev - 1);
			end
			wait_idle();
		end

		$display("Covered %0d levels in %0d spectra: field extremes, full store,", levels_sent,
			spectra_sent);
		$display("empty grid, clipped point count, energy overflow, stalls and a long hold-off.");
		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end
endmodule
